>>> sv/tmdr_pkg.sv
// ----------------------------------------------------------------------------
// tmdr_pkg - shared definitions for the three-motor duty ramp controller
// Command codes, duty limits, beat widths, the duty step helper and the pin helper.
// ----------------------------------------------------------------------------
package tmdr_pkg;

    localparam int DUTY_W   = 7;
    localparam int TARGET_W = 8;
    localparam int MODE_W   = 4;
    localparam int PINS_W   = 3;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 32;

    localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;
    localparam logic [DUTY_W-1:0] DUTY_ZERO = 7'd0;

    localparam logic [MODE_W-1:0] MODE_BRAKE      = 4'd0;
    localparam logic [MODE_W-1:0] MODE_FWD        = 4'd1;
    localparam logic [MODE_W-1:0] MODE_BACK       = 4'd2;
    localparam logic [MODE_W-1:0] MODE_LEFT       = 4'd3;
    localparam logic [MODE_W-1:0] MODE_RIGHT      = 4'd4;
    localparam logic [MODE_W-1:0] MODE_FWD_RIGHT  = 4'd5;
    localparam logic [MODE_W-1:0] MODE_FWD_LEFT   = 4'd6;
    localparam logic [MODE_W-1:0] MODE_BACK_RIGHT = 4'd7;
    localparam logic [MODE_W-1:0] MODE_BACK_LEFT  = 4'd8;

    typedef logic [DUTY_W-1:0] duty_t;

    function automatic duty_t ramp_toward(input duty_t cur, input duty_t goal);
        duty_t res;
        if (goal > cur) begin
            res = duty_t'(cur + 7'd1);
        end else if (goal < cur) begin
            res = duty_t'(cur - 7'd1);
        end else begin
            res = cur;
        end
        return res;
    endfunction

    // Replace the pins of the selected motors; A side low half, B side high half.
    function automatic logic [2*PINS_W-1:0] set_pins(
        input logic [2*PINS_W-1:0] cur,
        input logic [PINS_W-1:0]   a,
        input logic [PINS_W-1:0]   b,
        input logic [PINS_W-1:0]   mask
    );
        logic [2*PINS_W-1:0] m6;
        logic [2*PINS_W-1:0] v6;
        m6 = {mask, mask};
        v6 = {b, a};
        return (cur & ~m6) | (v6 & m6);
    endfunction

endpackage

>>> sv/three_motor_duty_ramp_controller.sv
// ----------------------------------------------------------------------------
// three_motor_duty_ramp_controller - duty ramp and direction pins, three motors
// Each known command updates duties, started flag and pins (turns also the phase);
// every beat returns one result beat with the new duties and pin levels.
// ----------------------------------------------------------------------------
// An accepted beat is held in the input register, then its result in the m_ register.
// Throughput: one beat per cycle while m_tready stays high; the step is one
// pass of compare-and-step logic between the input and result registers.
// Reset: duties, started flag, turn phase and all pins clear; both stages
// come up empty.
module three_motor_duty_ramp_controller
    import tmdr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [3:0] mode, [11:4] target_duty, [15:12] zero
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // [6:0] duty_one, [13:7] duty_two,
                                           // [20:14] duty_three, [23:21] pins_a,
                                           // [26:24] pins_b, [31:27] zero
);

    logic                  in_valid_reg;
    logic [MODE_W-1:0]     in_mode_reg;
    logic [TARGET_W-1:0]   in_target_reg;

    duty_t                 duty_reg [3];
    duty_t                 duty_next [3];
    logic                  started_reg, started_next;
    logic                  phase_reg, phase_next;
    logic [2*PINS_W-1:0]   pins_reg, pins_next;

    logic                  out_valid_reg;
    logic [M_DATA_W-1:0]   out_data_reg;

    logic                  out_free;
    logic                  fire;
    duty_t                 tgt;
    duty_t                 half;
    duty_t                 base [3];
    int                    slow;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || fire;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign tgt  = (in_target_reg > TARGET_W'(DUTY_FULL)) ? DUTY_FULL
                                                         : in_target_reg[DUTY_W-1:0];
    assign half = tgt >> 1;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            duty_next[k] = duty_reg[k];
        end
        started_next = started_reg;
        phase_next   = phase_reg;
        pins_next    = pins_reg;
        slow         = 0;
        base[0]      = started_reg ? duty_reg[0] : DUTY_FULL;
        base[1]      = started_reg ? duty_reg[1] : DUTY_FULL;
        base[2]      = started_reg ? duty_reg[2] : DUTY_FULL;

        case (in_mode_reg) inside
            MODE_BRAKE: begin
                for (int k = 0; k < 3; k++) begin
                    duty_next[k] = DUTY_ZERO;
                end
                started_next = 1'b0;
                pins_next    = set_pins(pins_reg, 3'b100, 3'b100, 3'b111);
            end
            MODE_FWD, MODE_BACK: begin
                started_next = 1'b1;
                for (int k = 0; k < 3; k++) begin
                    duty_next[k] = ramp_toward(base[k], tgt);
                end
                if (in_mode_reg == MODE_FWD) begin
                    pins_next = set_pins(pins_reg, 3'b111, 3'b000, 3'b111);
                end else begin
                    pins_next = set_pins(pins_reg, 3'b000, 3'b111, 3'b111);
                end
            end
            MODE_LEFT, MODE_RIGHT: begin
                started_next = 1'b1;
                duty_next[0] = ramp_toward(base[0], tgt);
                duty_next[1] = ramp_toward(base[1], tgt);
                duty_next[2] = started_reg ? duty_reg[2] : DUTY_ZERO;
                if (in_mode_reg == MODE_LEFT) begin
                    pins_next = set_pins(pins_reg, 3'b001, 3'b010, 3'b011);
                end else begin
                    pins_next = set_pins(pins_reg, 3'b010, 3'b001, 3'b011);
                end
            end
            MODE_FWD_RIGHT, MODE_FWD_LEFT, MODE_BACK_RIGHT, MODE_BACK_LEFT: begin
                started_next = 1'b1;
                slow = (in_mode_reg == MODE_FWD_RIGHT || in_mode_reg == MODE_BACK_RIGHT)
                       ? 1 : 0;
                for (int k = 0; k < 3; k++) begin
                    if (k == slow) begin
                        duty_next[k] = phase_reg ? ramp_toward(base[k], half) : base[k];
                    end else begin
                        duty_next[k] = ramp_toward(base[k], tgt);
                    end
                end
                phase_next = !phase_reg;
                if (in_mode_reg == MODE_FWD_RIGHT || in_mode_reg == MODE_FWD_LEFT) begin
                    pins_next = set_pins(pins_reg, 3'b111, 3'b000, 3'b111);
                end else begin
                    pins_next = set_pins(pins_reg, 3'b000, 3'b111, 3'b111);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            started_reg   <= 1'b0;
            phase_reg     <= 1'b0;
            pins_reg      <= '0;
            for (int k = 0; k < 3; k++) begin
                duty_reg[k] <= DUTY_ZERO;
            end
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
                started_reg   <= started_next;
                phase_reg     <= phase_next;
                pins_reg      <= pins_next;
                for (int k = 0; k < 3; k++) begin
                    duty_reg[k] <= duty_next[k];
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_mode_reg   <= s_tdata[MODE_W-1:0];
            in_target_reg <= s_tdata[MODE_W +: TARGET_W];
        end
        if (fire) begin
            out_data_reg <= {5'd0, pins_next[2*PINS_W-1:PINS_W], pins_next[PINS_W-1:0],
                             duty_next[2], duty_next[1], duty_next[0]};
        end
    end

    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[6:0] <= DUTY_FULL && m_tdata[13:7] <= DUTY_FULL
                      && m_tdata[20:14] <= DUTY_FULL))
        else $error("duty above full scale");

    a_brake_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_mode_reg == MODE_BRAKE) |=>
            (!started_reg && duty_reg[0] == DUTY_ZERO && duty_reg[1] == DUTY_ZERO
             && duty_reg[2] == DUTY_ZERO && pins_reg == 6'b100100))
        else $error("brake did not clear state");

    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> ($stable(pins_reg) && $stable(phase_reg) && $stable(started_reg)
                   && $stable(duty_reg[0]) && $stable(duty_reg[1]) && $stable(duty_reg[2])))
        else $error("state changed without a step");

    a_result_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> (m_tvalid && m_tdata[6:0] == duty_reg[0] && m_tdata[26:21] == pins_reg))
        else $error("result beat differs from stored state");

endmodule
